>>> rtl/arx_pkg.sv
package arx_pkg;

	localparam int NA_TAPS   = 3;
	localparam int NB_TAPS   = 3;
	localparam int MAX_DELAY = 8;
	localparam int IN_DEPTH  = NB_TAPS + MAX_DELAY;

	// Coefficient registers exist for three taps on each side.
	localparam int COEF_REGS = 3;

	localparam int SAMPLE_W = 16;
	localparam int COEF_W   = 16;
	localparam int DELAY_W  = 4;
	localparam int DATA_W   = 32;

	localparam int HIST_IDX_W = $clog2(IN_DEPTH);
	localparam int PROD_W     = SAMPLE_W + COEF_W;
	localparam int BSUM_W     = PROD_W + $clog2(NB_TAPS + 1) + 1;
	localparam int ACC_W      = PROD_W + $clog2(NA_TAPS + NB_TAPS + 1) + 1;
	localparam int FRAC_SHIFT = 14;
	localparam int ROUND_HALF = 1 << (FRAC_SHIFT - 1);
	localparam int ROUND_W    = ACC_W - FRAC_SHIFT;

	localparam int Y_MAX = 32767;
	localparam int Y_MIN = -32768;

	localparam int REG_IDX_W = $clog2(2 * COEF_REGS + 1);
	localparam int PADDR_W   = REG_IDX_W + 2;

	localparam logic [REG_IDX_W-1:0] REG_A_COEF_0    = REG_IDX_W'(0);
	localparam logic [REG_IDX_W-1:0] REG_B_COEF_0    = REG_IDX_W'(COEF_REGS);
	localparam logic [REG_IDX_W-1:0] REG_INPUT_DELAY = REG_IDX_W'(2 * COEF_REGS);

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic signed [COEF_W-1:0]   coef_t;
	typedef logic signed [PROD_W-1:0]   prod_t;

	typedef struct packed {
		coef_t [NA_TAPS-1:0]  a_coef;
		coef_t [NB_TAPS-1:0]  b_coef;
		logic  [DELAY_W-1:0]  input_delay;
	} cfg_t;

	// Partial result handed from the input stage to the output stage.
	typedef struct packed {
		logic                     valid;
		logic signed [BSUM_W-1:0] bsum;
	} fwd_t;

endpackage

>>> rtl/arx_if.sv
interface arx_in_if;
	logic              valid;
	logic              ready;
	arx_pkg::sample_t  u_sample;
	arx_pkg::sample_t  noise_sample;

	modport source (output valid, output u_sample, output noise_sample, input ready);
	modport sink (input valid, input u_sample, input noise_sample, output ready);
endinterface

interface arx_out_if;
	logic              valid;
	logic              ready;
	arx_pkg::sample_t  y_sample;
	logic              saturated;

	modport source (output valid, output y_sample, output saturated, input ready);
	modport sink (input valid, input y_sample, input saturated, output ready);
endinterface

>>> rtl/arx_cfg_regs.sv
module arx_cfg_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [arx_pkg::PADDR_W-1:0]  paddr,
	input  logic [arx_pkg::DATA_W-1:0]   pwdata,
	output logic [arx_pkg::DATA_W-1:0]   prdata,
	output logic                         pready,
	output arx_pkg::cfg_t                cfg
);

	arx_pkg::cfg_t                    cfg_q;
	logic [arx_pkg::REG_IDX_W-1:0]    reg_idx;
	logic                             wr_en;

	assign reg_idx = paddr[arx_pkg::PADDR_W-1:2];
	assign wr_en   = psel && penable && pwrite;
	assign pready  = 1'b1;
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			for (int i = 0; i < arx_pkg::NA_TAPS; i++) begin
				if (i < arx_pkg::COEF_REGS &&
				    reg_idx == arx_pkg::REG_IDX_W'(arx_pkg::REG_A_COEF_0 + i)) begin
					cfg_q.a_coef[i] <= pwdata[arx_pkg::COEF_W-1:0];
				end
			end
			for (int i = 0; i < arx_pkg::NB_TAPS; i++) begin
				if (i < arx_pkg::COEF_REGS &&
				    reg_idx == arx_pkg::REG_IDX_W'(arx_pkg::REG_B_COEF_0 + i)) begin
					cfg_q.b_coef[i] <= pwdata[arx_pkg::COEF_W-1:0];
				end
			end
			if (reg_idx == arx_pkg::REG_INPUT_DELAY) begin
				cfg_q.input_delay <= pwdata[arx_pkg::DELAY_W-1:0];
			end
		end
	end

	always_comb begin
		prdata = '0;
		for (int i = 0; i < arx_pkg::NA_TAPS; i++) begin
			if (i < arx_pkg::COEF_REGS &&
			    reg_idx == arx_pkg::REG_IDX_W'(arx_pkg::REG_A_COEF_0 + i)) begin
				prdata[arx_pkg::COEF_W-1:0] = cfg_q.a_coef[i];
			end
		end
		for (int i = 0; i < arx_pkg::NB_TAPS; i++) begin
			if (i < arx_pkg::COEF_REGS &&
			    reg_idx == arx_pkg::REG_IDX_W'(arx_pkg::REG_B_COEF_0 + i)) begin
				prdata[arx_pkg::COEF_W-1:0] = cfg_q.b_coef[i];
			end
		end
		if (reg_idx == arx_pkg::REG_INPUT_DELAY) begin
			prdata[arx_pkg::DELAY_W-1:0] = cfg_q.input_delay;
		end
	end

endmodule

>>> rtl/arx_in_stage.sv
module arx_in_stage (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  arx_pkg::sample_t  u_sample,
	input  arx_pkg::sample_t  noise_sample,
	input  arx_pkg::cfg_t     cfg,
	input  logic              advance,
	output arx_pkg::fwd_t     fwd
);

	arx_pkg::sample_t                  hist_q  [arx_pkg::IN_DEPTH];
	arx_pkg::sample_t                  hist_nx [arx_pkg::IN_DEPTH];
	arx_pkg::prod_t                    prod    [arx_pkg::NB_TAPS];
	logic [arx_pkg::HIST_IDX_W-1:0]    kc;
	logic [arx_pkg::HIST_IDX_W-1:0]    tap_idx [arx_pkg::NB_TAPS];
	logic signed [arx_pkg::BSUM_W-1:0] bsum_nx;
	logic signed [arx_pkg::BSUM_W-1:0] bsum_s1;
	logic                              valid_s1;
	logic                              accept;

	assign in_ready = !valid_s1 || advance;
	assign accept   = in_valid && in_ready;

	// Delays beyond MAX_DELAY act as the longest delay.
	assign kc = (int'(cfg.input_delay) > arx_pkg::MAX_DELAY) ?
	            arx_pkg::HIST_IDX_W'(arx_pkg::MAX_DELAY) :
	            arx_pkg::HIST_IDX_W'(cfg.input_delay);

	// The taps are read from the line as it stands after the new sample enters.
	always_comb begin
		hist_nx[0] = u_sample;
		for (int j = 1; j < arx_pkg::IN_DEPTH; j++) begin
			hist_nx[j] = hist_q[j-1];
		end
		bsum_nx = arx_pkg::BSUM_W'(noise_sample) <<< arx_pkg::FRAC_SHIFT;
		for (int i = 0; i < arx_pkg::NB_TAPS; i++) begin
			tap_idx[i] = kc + arx_pkg::HIST_IDX_W'(i);
			prod[i]    = cfg.b_coef[i] * hist_nx[tap_idx[i]];
			bsum_nx    = bsum_nx + arx_pkg::BSUM_W'(prod[i]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < arx_pkg::IN_DEPTH; j++) begin
				hist_q[j] <= '0;
			end
			valid_s1 <= 1'b0;
		end else begin
			if (accept) begin
				hist_q   <= hist_nx;
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			bsum_s1 <= bsum_nx;
		end
	end

	assign fwd.valid = valid_s1;
	assign fwd.bsum  = bsum_s1;

endmodule

>>> rtl/arx_out_stage.sv
module arx_out_stage (
	input  logic              clk,
	input  logic              arst_n,
	input  arx_pkg::fwd_t     fwd,
	input  arx_pkg::cfg_t     cfg,
	output logic              advance,
	output logic              out_valid,
	input  logic              out_ready,
	output arx_pkg::sample_t  y_sample,
	output logic              saturated
);

	arx_pkg::sample_t                   oh_q [arx_pkg::NA_TAPS];
	arx_pkg::prod_t                     prod [arx_pkg::NA_TAPS];
	logic signed [arx_pkg::ACC_W-1:0]   acc;
	logic signed [arx_pkg::ACC_W-1:0]   acc_r;
	logic signed [arx_pkg::ROUND_W-1:0] yr;
	logic                               sat_hi;
	logic                               sat_lo;
	arx_pkg::sample_t                   y_nx;
	arx_pkg::sample_t                   y_q;
	logic                               sat_q;
	logic                               out_valid_q;
	logic                               take;

	assign advance = !out_valid_q || out_ready;
	assign take    = advance && fwd.valid;

	always_comb begin
		acc = arx_pkg::ACC_W'(fwd.bsum);
		for (int i = 0; i < arx_pkg::NA_TAPS; i++) begin
			prod[i] = cfg.a_coef[i] * oh_q[i];
			acc     = acc - arx_pkg::ACC_W'(prod[i]);
		end
		// Adding one half and dropping the fraction rounds half toward plus infinity.
		acc_r  = acc + arx_pkg::ACC_W'(arx_pkg::ROUND_HALF);
		yr     = acc_r[arx_pkg::ACC_W-1:arx_pkg::FRAC_SHIFT];
		sat_hi = yr > arx_pkg::ROUND_W'(arx_pkg::Y_MAX);
		sat_lo = yr < arx_pkg::ROUND_W'(arx_pkg::Y_MIN);
		if (sat_hi) begin
			y_nx = arx_pkg::SAMPLE_W'(arx_pkg::Y_MAX);
		end else if (sat_lo) begin
			y_nx = arx_pkg::SAMPLE_W'(arx_pkg::Y_MIN);
		end else begin
			y_nx = yr[arx_pkg::SAMPLE_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < arx_pkg::NA_TAPS; i++) begin
				oh_q[i] <= '0;
			end
			out_valid_q <= 1'b0;
		end else begin
			if (take) begin
				oh_q[0] <= y_nx;
				for (int i = 1; i < arx_pkg::NA_TAPS; i++) begin
					oh_q[i] <= oh_q[i-1];
				end
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			y_q   <= y_nx;
			sat_q <= sat_hi || sat_lo;
		end
	end

	assign out_valid = out_valid_q;
	assign y_sample  = y_q;
	assign saturated = sat_q;

endmodule

>>> rtl/arx_model_step_unit.sv
// Channel   Dir  Payload                   Transfer when
// in_ch     in   u_sample, noise_sample    valid && ready
// out_ch    out  y_sample, saturated       valid && ready
// APB       in   seven config registers    psel && penable && pwrite (pready tied high)
//
// One sample per cycle while out_ch is ready; each stage registers a result in turn.
// The first stage shifts the input line and sums the input-side products; the second
// closes the feedback loop through the output history, rounds and clips.
// Reset clears the histories, the coefficients, the delay and both valid flags at once.
// A stalled output only holds the input side once the first stage is also occupied.
module arx_model_step_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [arx_pkg::PADDR_W-1:0]  paddr,
	input  logic [arx_pkg::DATA_W-1:0]   pwdata,
	output logic [arx_pkg::DATA_W-1:0]   prdata,
	output logic                         pready,
	arx_in_if.sink                       in_ch,
	arx_out_if.source                    out_ch
);

	arx_pkg::cfg_t cfg;
	arx_pkg::fwd_t fwd;
	logic          advance;

	arx_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	arx_in_stage u_in (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_ch.valid),
		.in_ready     (in_ch.ready),
		.u_sample     (in_ch.u_sample),
		.noise_sample (in_ch.noise_sample),
		.cfg          (cfg),
		.advance      (advance),
		.fwd          (fwd)
	);

	arx_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.fwd       (fwd),
		.cfg       (cfg),
		.advance   (advance),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.y_sample  (out_ch.y_sample),
		.saturated (out_ch.saturated)
	);

	// A clipped result must sit on one of the two rails.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.saturated |->
		(out_ch.y_sample == arx_pkg::SAMPLE_W'(arx_pkg::Y_MAX) ||
		 out_ch.y_sample == arx_pkg::SAMPLE_W'(arx_pkg::Y_MIN)))
		else $error("saturated result not at a rail");

	// An accepted sample always occupies the first stage on the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_ch.valid && in_ch.ready |=> fwd.valid)
		else $error("accepted sample lost before the first stage");

	// A pending partial result is kept while the output is blocked.
	assert property (@(posedge clk) disable iff (!arst_n)
		fwd.valid && out_ch.valid && !out_ch.ready |=> fwd.valid && $stable(fwd.bsum))
		else $error("first stage dropped or changed while output stalled");

endmodule
